[sv/brl_pkg.sv]
`default_nettype none
package brl_pkg;

  // list geometry
  localparam int CAPACITY  = 16;
  localparam int KEY_BYTES = 8;

  // field widths
  localparam int OP_W   = 3;
  localparam int KEY_W  = 64;
  localparam int ABS_W  = 16;
  localparam int PAY_W  = 32;
  localparam int POS_W  = 5;
  localparam int OUTC_W = 5;

  // storage index and count widths
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  // only the low KEY_BYTES bytes of a key take part
  localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
    ((KEY_W'(1) << (8 * KEY_BYTES)) - KEY_W'(1));

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_MIN    = 3'd4;
  localparam logic [OP_W-1:0] OP_DROP   = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ABS_W-1:0] absences;
    logic [PAY_W-1:0] payload;
  } rec_t;

  // one write and one read address per cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    rec_t              wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  typedef struct packed {
    logic             ok;
    rec_t             rec;
    logic [CNT_W-1:0] removed;
    logic [CNT_W-1:0] size;
  } res_t;

endpackage
`default_nettype wire

[sv/brl_if.sv]
`default_nettype none
interface brl_in_if import brl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [KEY_W-1:0] entry_key;
  logic [ABS_W-1:0] entry_absences;
  logic [PAY_W-1:0] entry_payload;
  logic [POS_W-1:0] position;
  logic [ABS_W-1:0] absence_limit;

  modport source (output valid, opcode, entry_key, entry_absences, entry_payload,
                  position, absence_limit, input ready);
  modport sink   (input valid, opcode, entry_key, entry_absences, entry_payload,
                  position, absence_limit, output ready);
endinterface

interface brl_out_if import brl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [KEY_W-1:0]  out_key;
  logic [ABS_W-1:0]  out_absences;
  logic [PAY_W-1:0]  out_payload;
  logic [OUTC_W-1:0] removed_count;
  logic [OUTC_W-1:0] size_after;
  logic              is_empty;
  logic              is_full;

  modport source (output valid, ok, out_key, out_absences, out_payload, removed_count,
                  size_after, is_empty, is_full, input ready);
  modport sink   (input valid, ok, out_key, out_absences, out_payload, removed_count,
                  size_after, is_empty, is_full, output ready);
endinterface
`default_nettype wire

[sv/bounded_record_list_engine.sv]
`default_nettype none
// Ordered list of up to CAPACITY records (key, absence count, payload) with append,
// positional insert and read, remove by key, remove smallest, drop over an absence
// limit and clear; every operation returns exactly one result with ok and the new
// size. One operation is in work at a time. The list lives in a memory with one
// write and one registered read port, and every operation that touches several
// entries streams them through it one entry per cycle, past a single key compare
// unit. A finished result sits in an output register, so the next operation is
// taken while it waits for the sink.
module bounded_record_list_engine import brl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  brl_in_if.sink     in_ch,
  brl_out_if.source  out_ch
);

  mem_req_t         mem_req;
  rec_t             rd_data;
  logic [KEY_W-1:0] cmp_a;
  logic [KEY_W-1:0] cmp_b;
  cmp_res_t         cmp_res;
  logic             res_valid;
  res_t             res;
  logic             res_take;
  logic             out_valid_r;
  res_t             out_r;

  brl_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  brl_key_cmp u_key_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  brl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .cmp_a     (cmp_a),
    .cmp_b     (cmp_b),
    .cmp_res   (cmp_res),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // output register
  assign res_take = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.ok            = out_r.ok;
  assign out_ch.out_key       = out_r.rec.key;
  assign out_ch.out_absences  = out_r.rec.absences;
  assign out_ch.out_payload   = out_r.rec.payload;
  assign out_ch.removed_count = OUTC_W'(out_r.removed);
  assign out_ch.size_after    = OUTC_W'(out_r.size);
  assign out_ch.is_empty      = (out_r.size == '0);
  assign out_ch.is_full       = (out_r.size == CNT_W'(CAPACITY));

endmodule
`default_nettype wire

[sv/brl_store.sv]
`default_nettype none
module brl_store import brl_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output rec_t     rd_data
);

  rec_t mem [CAPACITY];

  // record array, registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule
`default_nettype wire

[sv/brl_key_cmp.sv]
`default_nettype none
module brl_key_cmp import brl_pkg::*; (
  input  logic [KEY_W-1:0] a,
  input  logic [KEY_W-1:0] b,
  output cmp_res_t         res
);

  // string compare, first byte most significant, zero byte terminates
  always_comb begin
    logic [7:0] x;
    logic [7:0] y;
    logic       done;
    done   = 1'b0;
    res.lt = 1'b0;
    res.eq = 1'b1;
    for (int i = 0; i < KEY_BYTES; i++) begin
      x = a[8 * (KEY_BYTES - 1 - i) +: 8];
      y = b[8 * (KEY_BYTES - 1 - i) +: 8];
      if (!done) begin
        if (x != y) begin
          res.lt = (x < y);
          res.eq = 1'b0;
          done   = 1'b1;
        end else if (x == 8'd0) begin
          done = 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[sv/brl_ctrl.sv]
`default_nettype none
module brl_ctrl import brl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  brl_in_if.sink           in_ch,
  output mem_req_t         mem_req,
  input  rec_t             rd_data,
  output logic [KEY_W-1:0] cmp_a,
  output logic [KEY_W-1:0] cmp_b,
  input  cmp_res_t         cmp_res,
  output logic             res_valid,
  output res_t             res,
  input  logic             res_take
);

  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_INS   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]       state_r,    state_nxt;
  logic [CNT_W-1:0] count_r,    count_nxt;
  logic [CNT_W-1:0] idx_r,      idx_nxt;
  logic [CNT_W-1:0] rem_r,      rem_nxt;
  logic [CNT_W-1:0] rdi_r,      rdi_nxt;
  logic             vld_r,      vld_nxt;
  logic             found_r,    found_nxt;
  logic [CNT_W-1:0] wptr_r,     wptr_nxt;
  logic [CNT_W-1:0] best_idx_r, best_idx_nxt;
  rec_t             best_rec_r, best_rec_nxt;
  logic             ok_r,       ok_nxt;
  rec_t             res_rec_r,  res_rec_nxt;
  logic [CNT_W-1:0] removed_r,  removed_nxt;

  logic [OP_W-1:0]  op_r;
  rec_t             new_rec_r;
  logic [POS_W-1:0] pos_r;
  logic [ABS_W-1:0] limit_r;

  logic             accept;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic [CNT_W-1:0] pos_m1;
  logic [CNT_W-1:0] cnt_p1;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] rdi_p1;
  logic [CNT_W-1:0] rdi_m1;
  logic             not_full;
  logic             ins_ok;
  logic             rd_ok;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // position checks against the current count
  assign pos_x    = CMP_W'(pos_r);
  assign cnt_x    = CMP_W'(count_r);
  assign pos_m1   = CNT_W'(pos_x - CMP_W'(1));
  assign cnt_p1   = count_r + CNT_W'(1);
  assign cnt_m1   = count_r - CNT_W'(1);
  assign rdi_p1   = rdi_r + CNT_W'(1);
  assign rdi_m1   = rdi_r - CNT_W'(1);
  assign not_full = (count_r < CNT_W'(CAPACITY));
  assign ins_ok   = not_full && (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
  assign rd_ok    = (pos_x != '0) && (pos_x <= cnt_x);

  // shared compare: search key, or the smallest key so far
  assign cmp_a = rd_data.key;
  assign cmp_b = (op_r == OP_MIN) ? best_rec_r.key : new_rec_r.key;

  assign res_valid   = (state_r == S_FIN);
  assign res.ok      = ok_r;
  assign res.rec     = res_rec_r;
  assign res.removed = removed_r;
  assign res.size    = count_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    rdi_nxt       = rdi_r;
    vld_nxt       = 1'b0;
    found_nxt     = found_r;
    wptr_nxt      = wptr_r;
    best_idx_nxt  = best_idx_r;
    best_rec_nxt  = best_rec_r;
    ok_nxt        = ok_r;
    res_rec_nxt   = res_rec_r;
    removed_nxt   = removed_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = count_r[ADDR_W-1:0];
    mem_req.wdata = new_rec_r;
    mem_req.raddr = idx_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ok_nxt      = 1'b0;
          res_rec_nxt = '0;
          removed_nxt = '0;
          found_nxt   = 1'b0;
          wptr_nxt    = '0;
          state_nxt   = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_FIN;
        unique case (op_r) inside
          OP_APPEND: begin
            if (not_full) begin
              mem_req.we = 1'b1;
              count_nxt  = cnt_p1;
              ok_nxt     = 1'b1;
            end
          end
          OP_INSERT: begin
            if (ins_ok) begin
              if (pos_x == cnt_x + CMP_W'(1)) begin
                mem_req.we = 1'b1;
                count_nxt  = cnt_p1;
                ok_nxt     = 1'b1;
              end else begin
                idx_nxt   = cnt_m1;
                rem_nxt   = count_r - pos_m1;
                state_nxt = S_INS;
              end
            end
          end
          OP_REMOVE, OP_MIN, OP_DROP: begin
            if (count_r == '0) begin
              ok_nxt = (op_r == OP_DROP);
            end else begin
              idx_nxt   = '0;
              rem_nxt   = count_r;
              state_nxt = S_SCAN;
            end
          end
          OP_READ: begin
            if (rd_ok) begin
              mem_req.raddr = pos_m1[ADDR_W-1:0];
              state_nxt     = S_RD;
            end
          end
          OP_CLEAR: begin
            if (count_r != '0) begin
              count_nxt = '0;
              ok_nxt    = 1'b1;
            end
          end
          default: begin
            ok_nxt = 1'b0;
          end
        endcase
      end

      // move entries one place up, top first, then drop the new record in
      S_INS: begin
        if (rem_r != '0) begin
          rdi_nxt = idx_r;
          vld_nxt = 1'b1;
          idx_nxt = idx_r - CNT_W'(1);
          rem_nxt = rem_r - CNT_W'(1);
        end
        if (vld_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = rdi_p1[ADDR_W-1:0];
          mem_req.wdata = rd_data;
        end else if (rem_r == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_m1[ADDR_W-1:0];
          count_nxt     = cnt_p1;
          ok_nxt        = 1'b1;
          state_nxt     = S_FIN;
        end
      end

      // stream all entries past the compare unit
      S_SCAN: begin
        if (rem_r != '0) begin
          rdi_nxt = idx_r;
          vld_nxt = 1'b1;
          idx_nxt = idx_r + CNT_W'(1);
          rem_nxt = rem_r - CNT_W'(1);
        end
        if (vld_r) begin
          case (op_r)
            OP_REMOVE: begin
              if (found_r) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = rdi_m1[ADDR_W-1:0];
                mem_req.wdata = rd_data;
              end else if (cmp_res.eq) begin
                found_nxt    = 1'b1;
                best_rec_nxt = rd_data;
              end
            end
            OP_MIN: begin
              if ((rdi_r == '0) || cmp_res.lt) begin
                best_rec_nxt = rd_data;
                best_idx_nxt = rdi_r;
              end
            end
            default: begin
              if (rd_data.absences <= limit_r) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = wptr_r[ADDR_W-1:0];
                mem_req.wdata = rd_data;
                wptr_nxt      = wptr_r + CNT_W'(1);
              end
            end
          endcase
        end else if (rem_r == '0) begin
          state_nxt = S_FIN;
          case (op_r)
            OP_REMOVE: begin
              if (found_r) begin
                ok_nxt      = 1'b1;
                res_rec_nxt = best_rec_r;
                count_nxt   = cnt_m1;
              end
            end
            OP_MIN: begin
              ok_nxt      = 1'b1;
              res_rec_nxt = best_rec_r;
              if (best_idx_r == cnt_m1) begin
                count_nxt = cnt_m1;
              end else begin
                idx_nxt   = best_idx_r + CNT_W'(1);
                rem_nxt   = cnt_m1 - best_idx_r;
                state_nxt = S_SHIFT;
              end
            end
            default: begin
              ok_nxt      = 1'b1;
              removed_nxt = count_r - wptr_r;
              count_nxt   = wptr_r;
            end
          endcase
        end
      end

      // close the gap left by the smallest entry
      S_SHIFT: begin
        if (rem_r != '0) begin
          rdi_nxt = idx_r;
          vld_nxt = 1'b1;
          idx_nxt = idx_r + CNT_W'(1);
          rem_nxt = rem_r - CNT_W'(1);
        end
        if (vld_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = rdi_m1[ADDR_W-1:0];
          mem_req.wdata = rd_data;
        end else if (rem_r == '0) begin
          count_nxt = cnt_m1;
          state_nxt = S_FIN;
        end
      end

      S_RD: begin
        ok_nxt      = 1'b1;
        res_rec_nxt = rd_data;
        state_nxt   = S_FIN;
      end

      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      vld_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      vld_r   <= vld_nxt;
      found_r <= found_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    rem_r      <= rem_nxt;
    rdi_r      <= rdi_nxt;
    wptr_r     <= wptr_nxt;
    best_idx_r <= best_idx_nxt;
    best_rec_r <= best_rec_nxt;
    ok_r       <= ok_nxt;
    res_rec_r  <= res_rec_nxt;
    removed_r  <= removed_nxt;
  end

  // capture the operation on input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r               <= in_ch.opcode;
      new_rec_r.key      <= in_ch.entry_key & KEY_MASK;
      new_rec_r.absences <= in_ch.entry_absences;
      new_rec_r.payload  <= in_ch.entry_payload;
      pos_r              <= in_ch.position;
      limit_r            <= in_ch.absence_limit;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (CNT_W'(mem_req.waddr) <= count_r))
    else $error("write beyond the list end");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("transfer not followed by dispatch");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> $stable(count_r))
    else $error("count changed while idle");

  a_found_remove: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && (state_r != S_IDLE)) |-> (op_r == OP_REMOVE))
    else $error("key hit outside remove by key");
`endif

endmodule
`default_nettype wire

[verif/bounded_record_list_engine_tb.sv]
`timescale 1ns / 1ps
module bounded_record_list_engine_tb;
  import brl_pkg::*;

  // opcode with no operation behind it
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  localparam int LONG_HOLD    = 60;
  localparam int DRAIN_CYCLES = 48;
  localparam int QUIET_LIMIT  = 3000;

  typedef struct {
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] entry_key;
    logic [ABS_W-1:0] entry_absences;
    logic [PAY_W-1:0] entry_payload;
    logic [POS_W-1:0] position;
    logic [ABS_W-1:0] absence_limit;
  } list_op_t;

  typedef struct {
    logic              ok;
    logic [KEY_W-1:0]  key;
    logic [ABS_W-1:0]  absences;
    logic [PAY_W-1:0]  payload;
    logic [OUTC_W-1:0] removed;
    logic [OUTC_W-1:0] size;
    logic              empty;
    logic              full;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  brl_in_if  in_bus ();
  brl_out_if out_bus ();

  bounded_record_list_engine u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #5 clk = ~clk;

  // shadow copy of the list
  rec_t shadow_recs [CAPACITY];
  int   shadow_len;

  list_result_t pending_list_results [$];
  int           err_count;
  bit           src_idle_on;
  bit           sink_idle_on;
  bit           hold_req;

  // string order of two keys: zero byte ends the string
  function automatic int key_order(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    logic [7:0] x;
    logic [7:0] y;
    int         i;
    for (i = 0; i < KEY_BYTES; i++) begin
      x = a[8*(KEY_BYTES-1-i) +: 8];
      y = b[8*(KEY_BYTES-1-i) +: 8];
      if (x != y) return (x < y) ? -1 : 1;
      if (x == 8'h00) return 0;
    end
    return 0;
  endfunction

  // apply one operation to the shadow list and return its result
  function automatic list_result_t apply_list_op(input list_op_t op);
    list_result_t     r;
    logic [KEY_W-1:0] key;
    int               pos;
    int               hit;
    int               idx;
    int               j;
    int               m;
    r   = '{default: '0};
    key = op.entry_key & KEY_MASK;
    pos = int'(op.position);
    hit = -1;
    case (op.opcode)
      OP_APPEND: begin
        if (shadow_len < CAPACITY) begin
          shadow_recs[shadow_len] = '{key: key, absences: op.entry_absences,
                                      payload: op.entry_payload};
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      OP_INSERT: begin
        if (shadow_len < CAPACITY && pos >= 1 && pos <= shadow_len + 1) begin
          for (idx = shadow_len; idx >= pos; idx--) shadow_recs[idx] = shadow_recs[idx-1];
          shadow_recs[pos-1] = '{key: key, absences: op.entry_absences,
                                 payload: op.entry_payload};
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        for (idx = 0; idx < shadow_len && hit < 0; idx++)
          if (key_order(shadow_recs[idx].key, key) == 0) hit = idx;
      end
      OP_READ: begin
        if (pos >= 1 && pos <= shadow_len) begin
          r.ok       = 1'b1;
          r.key      = shadow_recs[pos-1].key;
          r.absences = shadow_recs[pos-1].absences;
          r.payload  = shadow_recs[pos-1].payload;
        end
      end
      OP_MIN: begin
        if (shadow_len > 0) begin
          m = 0;
          for (idx = 1; idx < shadow_len; idx++)
            if (key_order(shadow_recs[idx].key, shadow_recs[m].key) < 0) m = idx;
          hit = m;
        end
      end
      OP_DROP: begin
        j = 0;
        for (idx = 0; idx < shadow_len; idx++) begin
          if (shadow_recs[idx].absences <= op.absence_limit) begin
            shadow_recs[j] = shadow_recs[idx];
            j++;
          end
        end
        r.removed  = OUTC_W'(shadow_len - j);
        shadow_len = j;
        r.ok       = 1'b1;
      end
      OP_CLEAR: begin
        if (shadow_len > 0) begin
          shadow_len = 0;
          r.ok       = 1'b1;
        end
      end
      default: ;
    endcase
    // removal by key or by smallest key shifts the tail left
    if (hit >= 0) begin
      r.ok       = 1'b1;
      r.key      = shadow_recs[hit].key;
      r.absences = shadow_recs[hit].absences;
      r.payload  = shadow_recs[hit].payload;
      for (idx = hit; idx + 1 < shadow_len; idx++) shadow_recs[idx] = shadow_recs[idx+1];
      shadow_len--;
    end
    r.size  = OUTC_W'(shadow_len);
    r.empty = (shadow_len == 0);
    r.full  = (shadow_len == CAPACITY);
    return r;
  endfunction

  // offer one operation, wait for its transfer, then record the expected result
  task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [ABS_W-1:0] absn, input logic [PAY_W-1:0] pay,
                         input logic [POS_W-1:0] pos, input logic [ABS_W-1:0] lim);
    list_op_t item;
    int       gap;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.opcode         <= op;
    in_bus.entry_key      <= key;
    in_bus.entry_absences <= absn;
    in_bus.entry_payload  <= pay;
    in_bus.position       <= pos;
    in_bus.absence_limit  <= lim;
    do @(posedge clk); while (!in_bus.ready);
    item = '{opcode: op, entry_key: key, entry_absences: absn, entry_payload: pay,
             position: pos, absence_limit: lim};
    pending_list_results.push_back(apply_list_op(item));
  endtask

  // random key: raw bits, a stored key, or a short string with or without junk after it
  function automatic logic [KEY_W-1:0] make_key();
    logic [KEY_W-1:0] k;
    int               len;
    int               b;
    int               mode;
    mode = $urandom_range(0, 9);
    k    = {$urandom, $urandom};
    if (mode < 2) return k;
    if (mode < 4 && shadow_len > 0) return shadow_recs[$urandom_range(0, shadow_len-1)].key;
    len = $urandom_range(0, KEY_BYTES);
    for (b = 0; b < KEY_BYTES; b++) begin
      if (b < len) k[8*(KEY_BYTES-1-b) +: 8] = 8'h41 + 8'($urandom_range(0, 3));
      else if (b == len || mode < 7) k[8*(KEY_BYTES-1-b) +: 8] = 8'h00;
    end
    return k;
  endfunction

  // search key: mostly a stored key, with the bytes after its end scrambled
  function automatic logic [KEY_W-1:0] make_search_key();
    logic [KEY_W-1:0] k;
    int               b;
    bit               seen_zero;
    if (shadow_len == 0 || $urandom_range(0, 3) == 0) return make_key();
    k         = shadow_recs[$urandom_range(0, shadow_len-1)].key;
    seen_zero = 1'b0;
    for (b = 0; b < KEY_BYTES; b++) begin
      if (seen_zero) begin
        if ($urandom_range(0, 1) == 1) k[8*(KEY_BYTES-1-b) +: 8] = 8'($urandom);
      end else if (k[8*(KEY_BYTES-1-b) +: 8] == 8'h00) begin
        seen_zero = 1'b1;
      end
    end
    return k;
  endfunction

  // mostly well-formed operations against the current list, some pure noise
  task automatic send_random_op();
    int               sel;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [ABS_W-1:0] absn;
    logic [PAY_W-1:0] pay;
    logic [POS_W-1:0] pos;
    logic [ABS_W-1:0] lim;
    sel  = $urandom_range(0, 99);
    absn = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
    pay  = $urandom;
    key  = make_key();
    pos  = POS_W'($urandom_range(1, shadow_len + 1));
    lim  = 16'($urandom_range(0, 20));
    op   = OP_APPEND;
    if (sel < 8) begin
      op   = OP_W'($urandom_range(0, 7));
      key  = {$urandom, $urandom};
      absn = 16'($urandom);
      pos  = POS_W'($urandom_range(0, 31));
      lim  = 16'($urandom);
    end else if (sel < 30) begin
      op = OP_APPEND;
    end else if (sel < 50) begin
      op = OP_INSERT;
    end else if (sel < 64) begin
      op  = OP_REMOVE;
      key = make_search_key();
    end else if (sel < 78) begin
      op  = OP_READ;
      pos = POS_W'($urandom_range(1, (shadow_len > 0) ? shadow_len : 1));
    end else if (sel < 88) begin
      op = OP_MIN;
    end else if (sel < 96) begin
      op = OP_DROP;
      if (shadow_len > 0)
        lim = shadow_recs[$urandom_range(0, shadow_len-1)].absences -
              16'($urandom_range(0, 1));
    end else begin
      op = OP_CLEAR;
    end
    send_op(op, key, absn, pay, pos, lim);
  endtask

  // operations on an empty list
  task automatic test_empty_list();
    send_op(OP_CLEAR, '0, '0, '0, '0, '0);
    send_op(OP_MIN, '0, '0, '0, '0, '0);
    send_op(OP_READ, '0, '0, '0, 5'd1, '0);
    send_op(OP_REMOVE, '0, '0, '0, '0, '0);
    send_op(OP_DROP, '0, '0, '0, '0, '0);
    send_op(OP_UNUSED, '1, '1, '1, '1, '1);
  endtask

  // fill to capacity through every insert form, then hit the bounds
  task automatic test_fill_and_bounds();
    int i;
    send_op(OP_APPEND, '1, '1, '1, '0, '0);
    send_op(OP_APPEND, '0, '0, '0, '0, '0);
    send_op(OP_INSERT, 64'h424f_4200_0000_0000, 16'd7, 32'h1234_5678, 5'd1, '0);
    send_op(OP_INSERT, 64'h5a00_0000_0000_0000, 16'd3, 32'h0, 5'd0, '0);
    send_op(OP_INSERT, 64'h5a00_0000_0000_0000, 16'd3, 32'h0, POS_W'(shadow_len + 2), '0);
    i = 0;
    while (shadow_len < CAPACITY) begin
      send_op(OP_INSERT, {8'h41 + 8'(i % 3), 8'h00, 48'($urandom)}, 16'(i * 997), $urandom,
              (i % 2 == 1) ? POS_W'(shadow_len / 2 + 1) : POS_W'(shadow_len + 1), '0);
      i++;
    end
    send_op(OP_APPEND, 64'h4600_0000_0000_0000, 16'd1, 32'd1, '0, '0);
    send_op(OP_INSERT, 64'h4600_0000_0000_0000, 16'd1, 32'd1, 5'd1, '0);
    send_op(OP_READ, '0, '0, '0, 5'd0, '0);
    send_op(OP_READ, '0, '0, '0, POS_W'(CAPACITY), '0);
    send_op(OP_READ, '0, '0, '0, POS_W'(CAPACITY + 1), '0);
    send_op(OP_READ, '0, '0, '0, '1, '0);
  endtask

  // string compare, ties on smallest key, and the drop thresholds
  task automatic test_string_keys();
    send_op(OP_REMOVE, 64'h4100_1234_5678_9abc, '0, '0, '0, '0);
    send_op(OP_MIN, '0, '0, '0, '0, '0);
    send_op(OP_MIN, '0, '0, '0, '0, '0);
    send_op(OP_REMOVE, 64'h5a5a_5a00_0000_0000, '0, '0, '0, '0);
    send_op(OP_READ, '0, '0, '0, 5'd1, '0);
    send_op(OP_DROP, '0, '0, '0, '0, 16'd5000);
    send_op(OP_DROP, '0, '0, '0, '0, '1);
    send_op(OP_DROP, '0, '0, '0, '0, '0);
    send_op(OP_CLEAR, '0, '0, '0, '0, '0);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    int n;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_req     = 1'b1;
    for (n = 0; n < 24; n++) send_random_op();
  endtask

  // random traffic, idle pattern redrawn every 50 operations
  task automatic test_random_ops(input int total, input bit with_idle);
    int n;
    for (n = 0; n < total; n++) begin
      if (n % 50 == 0) begin
        src_idle_on  = with_idle && ($urandom_range(0, 2) != 0);
        sink_idle_on = with_idle && ($urandom_range(0, 2) != 0);
      end
      send_random_op();
    end
  endtask

  // result side ready: random stalls and the long hold
  initial begin : sink_ready
    int stall_left;
    out_bus.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_bus.ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [KEY_W-1:0] exp_v,
                             input logic [KEY_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    list_result_t exp_r;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_list_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $time);
        err_count++;
      end else begin
        exp_r = pending_list_results.pop_front();
        check_field("ok", exp_r.ok, out_bus.ok);
        check_field("out_key", exp_r.key, out_bus.out_key);
        check_field("out_absences", exp_r.absences, out_bus.out_absences);
        check_field("out_payload", exp_r.payload, out_bus.out_payload);
        check_field("removed_count", exp_r.removed, out_bus.removed_count);
        check_field("size_after", exp_r.size, out_bus.size_after);
        check_field("is_empty", exp_r.empty, out_bus.is_empty);
        check_field("is_full", exp_r.full, out_bus.is_full);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : main_seq
    err_count    = 0;
    shadow_len   = 0;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_req     = 1'b0;
    rst_n                 <= 1'b0;
    in_bus.valid          <= 1'b0;
    in_bus.opcode         <= '0;
    in_bus.entry_key      <= '0;
    in_bus.entry_absences <= '0;
    in_bus.entry_payload  <= '0;
    in_bus.position       <= '0;
    in_bus.absence_limit  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_fill_and_bounds();
    test_string_keys();
    test_backpressure();
    test_random_ops(700, 1'b1);
    test_random_ops(300, 1'b0);
    in_bus.valid <= 1'b0;

    // drain outstanding results, then let the block settle
    while (pending_list_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
